// ----- design/rhc_pkg.sv -----
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int COMP_W = 8;

    localparam int FULL_SCALE     = 255;
    localparam int DEG_PER_SECTOR = 60;
    localparam int SECTORS        = 6;
    localparam int DEG_FULL       = DEG_PER_SECTOR * SECTORS;

    typedef logic [COMP_W-1:0] comp_t;
    typedef logic [1:0] sector_t;

    localparam sector_t SECT_RED      = 2'd0;
    localparam sector_t SECT_RED_WRAP = 2'd1;
    localparam sector_t SECT_GREEN    = 2'd2;
    localparam sector_t SECT_BLUE     = 2'd3;

endpackage

// ----- design/rhc_pipe_ctrl.sv -----
`timescale 1ns / 1ps

module rhc_pipe_ctrl #(
    parameter int DEPTH = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [DEPTH-1:0] adv
);

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    // A stage may load when the output is being taken or some stage at or after it is empty.
    for (genvar i = 0; i < DEPTH; i++) begin : g_adv
        assign adv[i] = m_ready | ~(&valid_reg[DEPTH-1:i]);
    end

    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < DEPTH; i++) begin
            if (adv[i]) begin
                valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[DEPTH-1];

endmodule

// ----- design/rhc_front.sv -----
`timescale 1ns / 1ps

module rhc_front #(
    parameter int HUE_FRAC_BITS   = 6,
    parameter int LEVEL_FRAC_BITS = 16,
    parameter int HUE_NUM_W       = HUE_FRAC_BITS + 19,
    parameter int SAT_NUM_W       = LEVEL_FRAC_BITS + 18
) (
    input  logic                   aclk,
    input  logic [1:0]             adv,
    input  rhc_pkg::comp_t         red,
    input  rhc_pkg::comp_t         green,
    input  rhc_pkg::comp_t         blue,
    output logic [HUE_NUM_W-1:0]   hue_num,
    output logic [8:0]             hue_den,
    output logic [SAT_NUM_W-1:0]   sat_num,
    output logic [8:0]             sat_den,
    output logic [LEVEL_FRAC_BITS:0] light,
    output logic                   grey
);

    localparam int TWO_FULL  = 2 * rhc_pkg::FULL_SCALE;
    localparam int LEVEL_W   = LEVEL_FRAC_BITS + 1;
    localparam int LIGHT_X_W = LEVEL_FRAC_BITS + 8;
    localparam int LIGHT_M_W = LEVEL_FRAC_BITS + 9;
    localparam int LIGHT_P_W = LIGHT_X_W + LIGHT_M_W;
    localparam int LIGHT_SH  = LEVEL_FRAC_BITS + 16;
    localparam logic [LIGHT_M_W-1:0] LIGHT_RECIP =
        LIGHT_M_W'(((64'd1 << LIGHT_SH) + 64'(rhc_pkg::FULL_SCALE - 1))
                   / 64'(rhc_pkg::FULL_SCALE));

    rhc_pkg::comp_t     mx_next, mn_next, mx_reg, mn_reg;
    rhc_pkg::sector_t   sect_next, sect_reg;
    logic signed [8:0]  diff_next, diff_reg;

    logic                 red_max, green_max;
    logic                 red_min, green_min;

    always_comb begin
        red_max   = (red >= green) && (red >= blue);
        green_max = (green >= blue);
        red_min   = (red <= green) && (red <= blue);
        green_min = (green <= blue);
        mx_next   = red_max ? red : (green_max ? green : blue);
        mn_next   = red_min ? red : (green_min ? green : blue);
        if (red_max) begin
            sect_next = (blue > green) ? rhc_pkg::SECT_RED_WRAP : rhc_pkg::SECT_RED;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green_max) begin
            sect_next = rhc_pkg::SECT_GREEN;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            sect_next = rhc_pkg::SECT_BLUE;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            mx_reg   <= mx_next;
            mn_reg   <= mn_next;
            sect_reg <= sect_next;
            diff_reg <= diff_next;
        end
    end

    rhc_pkg::comp_t        chroma;
    logic [8:0]            sum;
    rhc_pkg::comp_t        dnm;
    logic [10:0]           base_c;
    logic signed [11:0]    angle_s;
    logic [16:0]           angle_num;
    logic [LIGHT_X_W-1:0]  light_x;
    logic [LIGHT_P_W-1:0]  light_prod;

    logic [HUE_NUM_W-1:0]   hue_num_next, hue_num_reg;
    logic [8:0]             hue_den_reg;
    logic [SAT_NUM_W-1:0]   sat_num_next, sat_num_reg;
    logic [8:0]             sat_den_reg;
    logic [LEVEL_W-1:0]     light_next, light_reg;
    logic                   grey_reg;

    // Lightness is the sum over 510, rounded half up. After the exact division by two,
    // the division by 255 is a multiplication by a rounded-up reciprocal, which is exact
    // over the whole range of the sum.
    always_comb begin
        chroma = mx_reg - mn_reg;
        sum    = {1'b0, mx_reg} + {1'b0, mn_reg};
        dnm    = (sum <= 9'(rhc_pkg::FULL_SCALE)) ? sum[7:0] : 8'(9'(TWO_FULL) - sum);
        case (sect_reg)
            rhc_pkg::SECT_RED_WRAP: base_c = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};
            rhc_pkg::SECT_GREEN:    base_c = {2'b00, chroma, 1'b0};
            rhc_pkg::SECT_BLUE:     base_c = {1'b0, chroma, 2'b00};
            default:                base_c = '0;
        endcase
        angle_s   = $signed({1'b0, base_c}) + 12'(diff_reg);
        angle_num = 17'(angle_s[10:0]) * 17'(rhc_pkg::DEG_PER_SECTOR);

        hue_num_next   = (HUE_NUM_W'(angle_num) << (HUE_FRAC_BITS + 1))
                       + HUE_NUM_W'(chroma);
        sat_num_next   = ((SAT_NUM_W'(chroma) * SAT_NUM_W'(TWO_FULL)) << LEVEL_FRAC_BITS)
                       + SAT_NUM_W'(dnm);
        light_x        = {sum, (LEVEL_FRAC_BITS - 1)'(rhc_pkg::FULL_SCALE / 2)};
        light_prod     = LIGHT_P_W'(light_x) * LIGHT_P_W'(LIGHT_RECIP);
        light_next     = light_prod[LIGHT_SH +: LEVEL_W];
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            hue_num_reg   <= hue_num_next;
            hue_den_reg   <= {chroma, 1'b0};
            sat_num_reg   <= sat_num_next;
            sat_den_reg   <= {dnm, 1'b0};
            light_reg     <= light_next;
            grey_reg      <= (chroma == '0);
        end
    end

    assign hue_num   = hue_num_reg;
    assign hue_den   = hue_den_reg;
    assign sat_num   = sat_num_reg;
    assign sat_den   = sat_den_reg;
    assign light     = light_reg;
    assign grey      = grey_reg;

endmodule

// ----- design/rhc_div.sv -----
`timescale 1ns / 1ps

module rhc_div #(
    parameter int NW = 25,
    parameter int DW = 9,
    parameter int QW = 17
) (
    input  logic          aclk,
    input  logic [QW-1:0] adv,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int EXT_W = NW + QW;

    logic [EXT_W-1:0] num_ext;
    logic [DW-1:0]    rem_init;

    // The quotient fits in QW bits, so the bits above them start out below the divisor.
    assign num_ext  = {{QW{1'b0}}, num};
    assign rem_init = DW'(num_ext >> QW);

    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = rem_init;
            assign den_in = den;
            assign low_in = num_ext[QW-1:0];
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                rem_reg[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
                den_reg[k] <= den_in;
                low_reg[k] <= low_in << 1;
                quo_reg[k] <= {quo_in[QW-2:0], take};
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ----- design/rgb_to_hsl_converter.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_red, s_green, s_blue (8 bits each)
// m_       out        m_valid / m_ready  m_hue, m_saturation, m_lightness
//
// One pixel may be accepted every cycle unless a full pipeline is stalled at the output;
// each request passes the front end, the QW-bit dividers and an output register, where QW is
// the larger of HUE_FRAC_BITS + 9 and LEVEL_FRAC_BITS + 8, with one quotient bit per divider stage.
// Reset clears only the stage valid bits, so the pipeline is empty after reset.
// A stall at the output holds only the full stages behind it; empty stages still fill.

module rgb_to_hsl_converter #(
    parameter int HUE_FRAC_BITS   = 6,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_red,
    input  logic [7:0]                 s_green,
    input  logic [7:0]                 s_blue,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [HUE_FRAC_BITS+8:0]   m_hue,
    output logic [LEVEL_FRAC_BITS:0]   m_saturation,
    output logic [LEVEL_FRAC_BITS:0]   m_lightness
);

    // Saturation can run up to 255 times full scale before it is cut to its width.
    localparam int HUE_W       = HUE_FRAC_BITS + 9;
    localparam int LEVEL_W     = LEVEL_FRAC_BITS + 1;
    localparam int SAT_QUO_W   = LEVEL_FRAC_BITS + 8;
    localparam int QW          = (HUE_W > SAT_QUO_W) ? HUE_W : SAT_QUO_W;
    localparam int HUE_NUM_W   = HUE_FRAC_BITS + 19;
    localparam int SAT_NUM_W   = LEVEL_FRAC_BITS + 18;
    localparam int DEPTH       = QW + 3;
    localparam logic [QW-1:0] HUE_FULL = QW'(rhc_pkg::DEG_FULL) << HUE_FRAC_BITS;

    logic [DEPTH-1:0] adv;

    rhc_pipe_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .adv     (adv)
    );

    logic [HUE_NUM_W-1:0]   hue_num;
    logic [8:0]             hue_den;
    logic [SAT_NUM_W-1:0]   sat_num;
    logic [8:0]             sat_den;
    logic [LEVEL_W-1:0]     light;
    logic                   grey;

    rhc_front #(
        .HUE_FRAC_BITS   (HUE_FRAC_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .HUE_NUM_W       (HUE_NUM_W),
        .SAT_NUM_W       (SAT_NUM_W)
    ) u_front (
        .aclk      (aclk),
        .adv       (adv[1:0]),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .hue_num   (hue_num),
        .hue_den   (hue_den),
        .sat_num   (sat_num),
        .sat_den   (sat_den),
        .light     (light),
        .grey      (grey)
    );

    logic [QW-1:0] hue_quo, sat_quo;

    rhc_div #(
        .NW(HUE_NUM_W),
        .DW(9),
        .QW(QW)
    ) u_div_hue (
        .aclk (aclk),
        .adv  (adv[QW+1:2]),
        .num  (hue_num),
        .den  (hue_den),
        .quo  (hue_quo)
    );

    rhc_div #(
        .NW(SAT_NUM_W),
        .DW(9),
        .QW(QW)
    ) u_div_sat (
        .aclk (aclk),
        .adv  (adv[QW+1:2]),
        .num  (sat_num),
        .den  (sat_den),
        .quo  (sat_quo)
    );

    logic [QW-1:0]      grey_reg;
    logic [LEVEL_W-1:0] light_pipe_reg [QW];

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QW; k++) begin
            if (adv[k+2]) begin
                grey_reg[k]       <= (k == 0) ? grey : grey_reg[(k == 0) ? 0 : k - 1];
                light_pipe_reg[k] <= (k == 0) ? light
                                              : light_pipe_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    logic [QW-1:0]      hue_wrap;
    logic [HUE_W-1:0]   hue_next, hue_reg;
    logic [LEVEL_W-1:0] sat_next, sat_reg;
    logic [LEVEL_W-1:0] light_reg;

    // A hue that rounds up to a full turn wraps to zero; grey pixels have no hue or saturation.
    always_comb begin
        hue_wrap = (hue_quo >= HUE_FULL) ? (hue_quo - HUE_FULL) : hue_quo;
        hue_next = grey_reg[QW-1] ? '0 : HUE_W'(hue_wrap);
        sat_next = grey_reg[QW-1] ? '0 : LEVEL_W'(sat_quo);
    end

    always_ff @(posedge aclk) begin
        if (adv[DEPTH-1]) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= light_pipe_reg[QW-1];
        end
    end

    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_lightness  = light_reg;

endmodule

// ----- sim/hsl_checker.sv -----
`timescale 1ns / 1ps

module hsl_checker #(
    parameter int HUE_FRAC_BITS   = 6,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [7:0]               s_red,
    input  logic [7:0]               s_green,
    input  logic [7:0]               s_blue,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [HUE_FRAC_BITS+8:0] m_hue,
    input  logic [LEVEL_FRAC_BITS:0] m_saturation,
    input  logic [LEVEL_FRAC_BITS:0] m_lightness,
    output int unsigned              errors,
    output int unsigned              pending
);

    localparam int HUE_W   = HUE_FRAC_BITS + 9;
    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] sat;
        logic [LEVEL_W-1:0] light;
    } hsl_t;

    hsl_t hsl_expected[$];
    int unsigned error_tally = 0;

    function automatic hsl_t predict_hsl(rhc_pkg::comp_t r, rhc_pkg::comp_t g,
                                         rhc_pkg::comp_t b);
        longint unsigned mx, mn, c, total, num, d;
        longint unsigned hue, sat, lig, hue_one, lev_one, hue_wrap;
        hsl_t res;
        hue_one  = 64'd1 << HUE_FRAC_BITS;
        lev_one  = 64'd1 << LEVEL_FRAC_BITS;
        hue_wrap = rhc_pkg::DEG_FULL * hue_one;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c     = mx - mn;
        total = mx + mn;
        hue   = 0;
        sat   = 0;
        lig   = (2 * total * lev_one + 2 * rhc_pkg::FULL_SCALE) / (4 * rhc_pkg::FULL_SCALE);
        if (c != 0) begin
            if (mx == r) begin
                if (g >= b) begin
                    num = rhc_pkg::DEG_PER_SECTOR * (g - b);
                end else begin
                    num = rhc_pkg::DEG_FULL * c - rhc_pkg::DEG_PER_SECTOR * (b - g);
                end
            end else if (mx == g) begin
                num = 2 * rhc_pkg::DEG_PER_SECTOR * c + rhc_pkg::DEG_PER_SECTOR * b
                    - rhc_pkg::DEG_PER_SECTOR * r;
            end else begin
                num = 4 * rhc_pkg::DEG_PER_SECTOR * c + rhc_pkg::DEG_PER_SECTOR * r
                    - rhc_pkg::DEG_PER_SECTOR * g;
            end
            hue = (2 * num * hue_one + c) / (2 * c);
            if (hue >= hue_wrap) hue -= hue_wrap;
            d = (total <= rhc_pkg::FULL_SCALE) ? total : (2 * rhc_pkg::FULL_SCALE - total);
            if (d != 0) sat = (2 * rhc_pkg::FULL_SCALE * c * lev_one + d) / (2 * d);
        end
        res.hue   = hue[HUE_W-1:0];
        res.sat   = sat[LEVEL_W-1:0];
        res.light = lig[LEVEL_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        hsl_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (hsl_expected.size() == 0) begin
                    $error("result with no request outstanding: hue %0d, sat %0d, light %0d",
                           m_hue, m_saturation, m_lightness);
                    error_tally++;
                end else begin
                    want = hsl_expected.pop_front();
                    if (m_hue !== want.hue) begin
                        $error("hue: expected %0d, got %0d", want.hue, m_hue);
                        error_tally++;
                    end
                    if (m_saturation !== want.sat) begin
                        $error("saturation: expected %0d, got %0d", want.sat, m_saturation);
                        error_tally++;
                    end
                    if (m_lightness !== want.light) begin
                        $error("lightness: expected %0d, got %0d", want.light, m_lightness);
                        error_tally++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                hsl_expected.push_back(predict_hsl(s_red, s_green, s_blue));
            end
        end
        errors  <= error_tally;
        pending <= hsl_expected.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int HUE_FRAC_BITS   = 6;
    localparam int LEVEL_FRAC_BITS = 16;
    localparam int RANDOM_PIXELS   = 1100;
    localparam int STALL_LIMIT     = 3000;

    localparam logic [23:0] DIRECTED [20] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF7F80,
        24'h010000, 24'h000100, 24'h000001, 24'h808080, 24'h010101,
        24'hFFFEFE, 24'h7F8080, 24'h807FFF, 24'hFEFFFF, 24'h80FF80
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_red   = '0;
    logic [7:0] s_green = '0;
    logic [7:0] s_blue  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [HUE_FRAC_BITS+8:0] m_hue;
    logic [LEVEL_FRAC_BITS:0] m_saturation;
    logic [LEVEL_FRAC_BITS:0] m_lightness;

    int unsigned errors;
    int unsigned pending;
    int unsigned idle_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    rgb_to_hsl_converter #(
        .HUE_FRAC_BITS  (HUE_FRAC_BITS),
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hue       (m_hue),
        .m_saturation(m_saturation),
        .m_lightness (m_lightness)
    );

    hsl_checker #(
        .HUE_FRAC_BITS  (HUE_FRAC_BITS),
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hue       (m_hue),
        .m_saturation(m_saturation),
        .m_lightness (m_lightness),
        .errors      (errors),
        .pending     (pending)
    );

    task automatic offer_pixel(input rhc_pkg::comp_t r, input rhc_pkg::comp_t g,
                               input rhc_pkg::comp_t b, input int unsigned gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic rhc_pkg::comp_t near_value(rhc_pkg::comp_t base);
        int v;
        v = int'(base) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return rhc_pkg::comp_t'(v);
    endfunction

    function automatic rhc_pkg::comp_t edge_value();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic void draw_pixel(output rhc_pkg::comp_t r, output rhc_pkg::comp_t g,
                                       output rhc_pkg::comp_t b);
        rhc_pkg::comp_t base;
        base = rhc_pkg::comp_t'($urandom);
        r = rhc_pkg::comp_t'($urandom);
        g = rhc_pkg::comp_t'($urandom);
        b = rhc_pkg::comp_t'($urandom);
        case ($urandom_range(0, 9))
            6: begin
                r = near_value(base);
                g = near_value(base);
                b = near_value(base);
            end
            7: begin
                r = edge_value();
                g = edge_value();
                b = edge_value();
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: g = r;
                    1: b = g;
                    default: r = b;
                endcase
            end
            9: begin
                r = base;
                g = base;
                b = base;
            end
            default: ;
        endcase
    endfunction

    // The receiver holds off once for a long stretch so that the pipeline fills and
    // the block stalls its input; for one stretch it takes results with no wait, elsewhere a random wait.
    initial begin : result_sink
        int unsigned wait_cycles;
        int unsigned taken;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 400) begin
                wait_cycles = 300;
            end else if (taken >= 500 && taken < 650) begin
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, 3);
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("FAIL rgb_to_hsl_converter");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : pixel_source
        rhc_pkg::comp_t r, g, b;
        int unsigned gap;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (DIRECTED[i]) begin
            offer_pixel(DIRECTED[i][23:16], DIRECTED[i][15:8], DIRECTED[i][7:0],
                        $urandom_range(0, 3));
        end
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            // Once in the run the source drains the pipeline completely before going on.
            if (n == 700) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            gap = (n >= 200 && n < 350) ? 0 : $urandom_range(0, 3);
            draw_pixel(r, g, b);
            offer_pixel(r, g, b, gap);
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS rgb_to_hsl_converter");
        end else begin
            $display("FAIL rgb_to_hsl_converter");
        end
        $finish;
    end

endmodule
